@@ hw/rtl/iaw_pkg.sv @@
// shared constants, codes and types for the inverse affine warp
// no dependencies; imported by every module of the block except iaw_ram
package iaw_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int FRAC_BITS  = 16;

   localparam int POS_W  = 9;
   localparam int PIX_W  = 8;
   localparam int DIM_W  = 10;
   localparam int COEF_W = 32;
   localparam int CSR_IDX_W = 3;

   localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int PROD_W = COEF_W + POS_W + 1;
   localparam int SUM_W  = PROD_W + 2;
   localparam int RND_W  = SUM_W - FRAC_BITS;

   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = QPTR_W + 1;
   localparam int OCC_W  = QCNT_W + 1;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_XX      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_XY      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_XT      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_YX      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_YY      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_YT      = 3'd7;

   typedef struct packed {
      logic              op;
      logic              hit;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  pixel;
   } iaw_entry_type;

   typedef struct packed {
      logic              empty;
      logic              full;
      logic [QCNT_W-1:0] count;
   } iaw_qstat_type;

endpackage

@@ hw/rtl/iaw_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module iaw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/iaw_front.sv @@
// front end: config registers, beat accept, coordinate mapping pipeline
// depends on iaw_pkg; pushes classified work into the queue
module iaw_front import iaw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic [POS_W-1:0]     req_pos_x,
   input  logic [POS_W-1:0]     req_pos_y,
   input  logic [PIX_W-1:0]     req_pixel_in,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata,
   input  iaw_qstat_type        qstat,
   output logic                 push,
   output iaw_entry_type        push_entry
);

   logic [DIM_W-1:0]         width_ff, width_in, height_ff, height_in;
   logic signed [COEF_W-1:0] cxx_ff, cxx_in, cxy_ff, cxy_in, cxt_ff, cxt_in;
   logic signed [COEF_W-1:0] cyx_ff, cyx_in, cyy_ff, cyy_in, cyt_ff, cyt_in;
   logic [DIM_W-1:0]         w_eff, h_eff;
   logic                     accept;

   // stage 1: products
   logic                     v1_ff, v1_in;
   logic                     op1_ff, ld1_ff, ld1_in;
   logic [POS_W-1:0]         x1_ff, y1_ff;
   logic [PIX_W-1:0]         pix1_ff;
   logic signed [PROD_W-1:0] pxx_ff, pxy_ff, pyx_ff, pyy_ff;
   logic signed [PROD_W-1:0] pxx_in, pxy_in, pyx_in, pyy_in;
   logic signed [COEF_W-1:0] tx1_ff, ty1_ff;

   // stage 2: sums
   logic                     v2_ff;
   logic                     op2_ff, ld2_ff;
   logic [POS_W-1:0]         x2_ff, y2_ff;
   logic [PIX_W-1:0]         pix2_ff;
   logic signed [SUM_W-1:0]  sx_ff, sy_ff, sx_in, sy_in;

   // stage 3: rounded coordinates
   logic                     v3_ff;
   logic                     op3_ff, ld3_ff;
   logic [POS_W-1:0]         x3_ff, y3_ff;
   logic [PIX_W-1:0]         pix3_ff;
   logic signed [SUM_W-1:0]  rx_sum, ry_sum;
   logic [RND_W-1:0]         rx_ff, ry_ff, rx_in, ry_in;

   logic [OCC_W-1:0]         occupancy;
   logic                     in_image;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      cxx_in = cxx_ff;
      cxy_in = cxy_ff;
      cxt_in = cxt_ff;
      cyx_in = cyx_ff;
      cyy_in = cyy_ff;
      cyt_in = cyt_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_wdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_wdata[DIM_W-1:0];
            REG_COEF_XX:      cxx_in = $signed(csr_wdata);
            REG_COEF_XY:      cxy_in = $signed(csr_wdata);
            REG_COEF_XT:      cxt_in = $signed(csr_wdata);
            REG_COEF_YX:      cyx_in = $signed(csr_wdata);
            REG_COEF_YY:      cyy_in = $signed(csr_wdata);
            REG_COEF_YT:      cyt_in = $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(MAX_WIDTH);
         height_ff <= DIM_W'(MAX_HEIGHT);
         cxx_ff <= COEF_W'(1 << FRAC_BITS);
         cxy_ff <= '0;
         cxt_ff <= '0;
         cyx_ff <= '0;
         cyy_ff <= COEF_W'(1 << FRAC_BITS);
         cyt_ff <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         cxx_ff <= cxx_in;
         cxy_ff <= cxy_in;
         cxt_ff <= cxt_in;
         cyx_ff <= cyx_in;
         cyy_ff <= cyy_in;
         cyt_ff <= cyt_in;
      end
   end

   assign w_eff = (width_ff > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_ff;

   // credit: every beat in flight has a queue slot reserved
   assign occupancy = OCC_W'(qstat.count) + OCC_W'(v1_ff) + OCC_W'(v2_ff) + OCC_W'(v3_ff);
   assign req_stall = occupancy >= OCC_W'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   assign v1_in  = accept;
   assign ld1_in = (DIM_W'(req_pos_x) < w_eff) && (DIM_W'(req_pos_y) < h_eff);
   assign pxx_in = PROD_W'(cxx_ff) * $signed(PROD_W'(req_pos_x));
   assign pxy_in = PROD_W'(cxy_ff) * $signed(PROD_W'(req_pos_y));
   assign pyx_in = PROD_W'(cyx_ff) * $signed(PROD_W'(req_pos_x));
   assign pyy_in = PROD_W'(cyy_ff) * $signed(PROD_W'(req_pos_y));

   assign sx_in = SUM_W'(pxx_ff) + SUM_W'(pxy_ff) + SUM_W'(tx1_ff);
   assign sy_in = SUM_W'(pyx_ff) + SUM_W'(pyy_ff) + SUM_W'(ty1_ff);

   // round half away from zero: add half, less one when negative, then floor
   assign rx_sum = sx_ff + $signed(ROUND_HALF) - $signed(SUM_W'(sx_ff[SUM_W-1]));
   assign ry_sum = sy_ff + $signed(ROUND_HALF) - $signed(SUM_W'(sy_ff[SUM_W-1]));
   assign rx_in  = RND_W'(rx_sum >>> FRAC_BITS);
   assign ry_in  = RND_W'(ry_sum >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff  <= req_operation;
      ld1_ff  <= ld1_in;
      x1_ff   <= req_pos_x;
      y1_ff   <= req_pos_y;
      pix1_ff <= req_pixel_in;
      pxx_ff  <= pxx_in;
      pxy_ff  <= pxy_in;
      pyx_ff  <= pyx_in;
      pyy_ff  <= pyy_in;
      tx1_ff  <= cxt_ff;
      ty1_ff  <= cyt_ff;

      op2_ff  <= op1_ff;
      ld2_ff  <= ld1_ff;
      x2_ff   <= x1_ff;
      y2_ff   <= y1_ff;
      pix2_ff <= pix1_ff;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;

      op3_ff  <= op2_ff;
      ld3_ff  <= ld2_ff;
      x3_ff   <= x2_ff;
      y3_ff   <= y2_ff;
      pix3_ff <= pix2_ff;
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
   end

   assign in_image = !rx_ff[RND_W-1] && !ry_ff[RND_W-1]
                  && (rx_ff < RND_W'(w_eff)) && (ry_ff < RND_W'(h_eff));

   always_comb begin
      push_entry.op    = op3_ff;
      push_entry.pixel = pix3_ff;
      if (op3_ff == OP_RENDER) begin
         push_entry.hit  = in_image;
         push_entry.addr = ADDR_W'(ADDR_W'(ry_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rx_ff));
         push = v3_ff;
      end else begin
         push_entry.hit  = ld3_ff;
         push_entry.addr = ADDR_W'(ADDR_W'(y3_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x3_ff));
         push = v3_ff && ld3_ff;
      end
   end

endmodule

@@ hw/rtl/iaw_queue.sv @@
// short in-order queue between front and back end
// depends on iaw_pkg
module iaw_queue import iaw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  iaw_entry_type push_entry,
   input  logic          pop,
   output iaw_entry_type head,
   output iaw_qstat_type qstat
);

   iaw_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head        = slot_ff[rd_ptr_ff];
   assign qstat.count = count_ff;
   assign qstat.empty = count_ff == '0;
   assign qstat.full  = count_ff == QCNT_W'(QUEUE_DEPTH);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && qstat.full && !pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && qstat.empty))
      else $error("queue pop while empty");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + QCNT_W'(1))
      else $error("queue count lost a push");

endmodule

@@ hw/rtl/iaw_back.sv @@
// back end: frame store writes and lookups, result register
// depends on iaw_pkg and iaw_ram; drains the queue
module iaw_back import iaw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  iaw_entry_type head,
   input  iaw_qstat_type qstat,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [PIX_W-1:0] rsp_pixel_out,
   output logic          rsp_inside_res
);

   logic             rd_v_ff, rd_v_in, rd_inside_ff, rd_inside_in;
   logic             out_v_ff, out_v_in, out_inside_ff, out_inside_in;
   logic [PIX_W-1:0] out_pix_ff, out_pix_in;
   logic             rd_adv, is_render;
   logic             wr_en, rd_en;
   logic [PIX_W-1:0] rd_data;

   assign is_render = head.op == OP_RENDER;
   assign rd_adv    = rd_v_ff && (!out_v_ff || !rsp_stall);
   assign pop       = !qstat.empty && (!is_render || !rd_v_ff || rd_adv);
   assign wr_en     = pop && !is_render;
   assign rd_en     = pop && is_render && head.hit;

   iaw_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH * MAX_HEIGHT)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (head.addr),
      .wr_data (head.pixel),
      .rd_en   (rd_en),
      .rd_addr (head.addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rd_v_in      = rd_v_ff;
      rd_inside_in = rd_inside_ff;
      if (pop && is_render) begin
         rd_v_in      = 1'b1;
         rd_inside_in = head.hit;
      end else if (rd_adv) begin
         rd_v_in = 1'b0;
      end
   end

   always_comb begin
      out_v_in      = out_v_ff;
      out_pix_in    = out_pix_ff;
      out_inside_in = out_inside_ff;
      if (rd_adv) begin
         out_v_in      = 1'b1;
         out_pix_in    = rd_inside_ff ? rd_data : '0;
         out_inside_in = rd_inside_ff;
      end else if (!rsp_stall) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         rd_v_ff  <= rd_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_inside_ff  <= rd_inside_in;
      out_pix_ff    <= out_pix_in;
      out_inside_ff <= out_inside_in;
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_pixel_out  = out_pix_ff;
   assign rsp_inside_res = out_inside_ff;

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_res |-> rsp_pixel_out == '0)
      else $error("outside beat carries a nonzero pixel");

   a_lookup_held: assert property (@(posedge clock) disable iff (reset)
      rd_v_ff && out_v_ff && rsp_stall |=> rd_v_ff && $stable(rd_data))
      else $error("pending lookup lost under stall");

endmodule

@@ hw/rtl/inverse_affine_warp_nearest.sv @@
// top level of the inverse affine warp with nearest neighbor sampling
// depends on iaw_pkg, iaw_front, iaw_queue, iaw_back (and iaw_ram below it)
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  operation, pos_x, pos_y, pixel_in
//   rsp      out  rsp_valid/rsp_stall  pixel_out, inside_res
//   csr      in   csr_wr_en            csr_index, csr_wdata
//
// one beat per cycle sustained on both sides while rsp is not stalled
// a render result goes through three mapping stages, queue, frame store read, result reg
// single frame store port pair: one load write or one lookup per cycle while rsp flows
// synchronous reset clears control and restores config; the frame store is not cleared
// req_stall rises when the eight-entry queue has no slot left for the beats in flight
module inverse_affine_warp_nearest import iaw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic [POS_W-1:0]     req_pos_x,
   input  logic [POS_W-1:0]     req_pos_y,
   input  logic [PIX_W-1:0]     req_pixel_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PIX_W-1:0]     rsp_pixel_out,
   output logic                 rsp_inside_res,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata
);

   iaw_qstat_type qstat;
   iaw_entry_type push_entry, head;
   logic          push, pop;

   iaw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pixel_in  (req_pixel_in),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .qstat         (qstat),
      .push          (push),
      .push_entry    (push_entry)
   );

   iaw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   iaw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .qstat          (qstat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_inside_res (rsp_inside_res)
   );

endmodule

@@ tb/tb_inverse_affine_warp_nearest.sv @@
// self-checking testbench for inverse_affine_warp_nearest
// keeps its own copy of the frame store and warp registers to predict each render beat
// depends on iaw_pkg and the rtl of the block, nothing else
module tb_inverse_affine_warp_nearest import iaw_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES  = 12;
   localparam int LONG_HOLD      = 300;
   localparam int QUIET_LIMIT    = 3000;
   localparam int RANDOM_BEATS   = 760;
   localparam int MAX_PRINTS     = 100;
   localparam int UNITY          = 1 << FRAC_BITS;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             hit;
   } warp_result_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_operation;
   logic [POS_W-1:0]     req_pos_x;
   logic [POS_W-1:0]     req_pos_y;
   logic [PIX_W-1:0]     req_pixel_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [PIX_W-1:0]     rsp_pixel_out;
   logic                 rsp_inside_res;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COEF_W-1:0]    csr_wdata;

   // predictor state
   logic [PIX_W-1:0]         source_frame [int];
   logic [DIM_W-1:0]         frame_w;
   logic [DIM_W-1:0]         frame_h;
   logic signed [COEF_W-1:0] m_xx, m_xy, m_xt, m_yx, m_yy, m_yt;
   warp_result_type          expected_pixels [$];

   int  beats_sent  = 0;
   int  mismatches  = 0;
   int  gap_next    = 0;
   bit  send_idle   = 1;
   bit  recv_idle   = 1;
   bit  hold_token  = 0;
   bit  hold_seen   = 0;
   int  stall_left  = 0;
   warp_result_type head;

   inverse_affine_warp_nearest DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_inside_res (rsp_inside_res),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int dim_width();
      return (frame_w > MAX_WIDTH) ? MAX_WIDTH : int'(frame_w);
   endfunction

   function automatic int dim_height();
      return (frame_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(frame_h);
   endfunction

   // half away from zero
   function automatic longint round_away(input longint v);
      longint half;
      half = longint'(1) <<< (FRAC_BITS - 1);
      if (v >= 0) return (v + half) >>> FRAC_BITS;
      return -((-v + half) >>> FRAC_BITS);
   endfunction

   // frame store address of the mapped source pixel, -1 when it falls outside
   function automatic int source_addr(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
      longint sx, sy;
      sx = round_away(longint'(m_xx) * longint'(x) + longint'(m_xy) * longint'(y)
                      + longint'(m_xt));
      sy = round_away(longint'(m_yx) * longint'(x) + longint'(m_yy) * longint'(y)
                      + longint'(m_yt));
      if (sx < 0 || sy < 0 || sx >= dim_width() || sy >= dim_height()) return -1;
      return int'(sy) * MAX_WIDTH + int'(sx);
   endfunction

   function automatic int spread(input int r);
      return int'($urandom_range(0, 2 * r)) - r;
   endfunction

   task automatic send_beat(input logic op, input logic [POS_W-1:0] x,
                            input logic [POS_W-1:0] y, input logic [PIX_W-1:0] pix);
      warp_result_type r;
      int addr;
      repeat (gap_next) @(posedge clock);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_pos_x     <= x;
      req_pos_y     <= y;
      req_pixel_in  <= pix;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      if (op == OP_LOAD) begin
         if (x < dim_width() && y < dim_height())
            source_frame[int'(y) * MAX_WIDTH + int'(x)] = pix;
      end else begin
         addr = source_addr(x, y);
         r.hit = (addr >= 0);
         r.pixel = (addr >= 0 && source_frame.exists(addr)) ? source_frame[addr] : '0;
         expected_pixels.push_back(r);
      end
      beats_sent++;
      gap_next = send_idle ? $urandom_range(0, 13) : 0;
      if (gap_next != 0) req_valid <= 1'b0;
   endtask

   // a render never reads an entry that was not loaded: load it first
   task automatic render_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
      int addr;
      addr = source_addr(x, y);
      if (addr >= 0 && !source_frame.exists(addr))
         send_beat(OP_LOAD, POS_W'(addr % MAX_WIDTH), POS_W'(addr / MAX_WIDTH),
                   PIX_W'($urandom));
      send_beat(OP_RENDER, x, y, PIX_W'($urandom));
   endtask

   task automatic drain_results();
      if (gap_next == 0) req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_IMAGE_WIDTH:  frame_w = data[DIM_W-1:0];
         REG_IMAGE_HEIGHT: frame_h = data[DIM_W-1:0];
         REG_COEF_XX:      m_xx = data;
         REG_COEF_XY:      m_xy = data;
         REG_COEF_XT:      m_xt = data;
         REG_COEF_YX:      m_yx = data;
         REG_COEF_YY:      m_yy = data;
         REG_COEF_YT:      m_yt = data;
         default: ;
      endcase
   endtask

   task automatic configure(input int unsigned w, input int unsigned h,
                            input logic signed [COEF_W-1:0] xx, input logic signed [COEF_W-1:0] xy,
                            input logic signed [COEF_W-1:0] xt, input logic signed [COEF_W-1:0] yx,
                            input logic signed [COEF_W-1:0] yy, input logic signed [COEF_W-1:0] yt);
      logic [COEF_W-1:0] dim;
      drain_results();
      // upper bits of the dimension words are don't care
      dim = $urandom;
      dim[DIM_W-1:0] = w[DIM_W-1:0];
      write_reg(REG_IMAGE_WIDTH, dim);
      dim = $urandom;
      dim[DIM_W-1:0] = h[DIM_W-1:0];
      write_reg(REG_IMAGE_HEIGHT, dim);
      write_reg(REG_COEF_XX, xx);
      write_reg(REG_COEF_XY, xy);
      write_reg(REG_COEF_XT, xt);
      write_reg(REG_COEF_YX, yx);
      write_reg(REG_COEF_YY, yy);
      write_reg(REG_COEF_YT, yt);
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_corners();
      send_beat(OP_LOAD, 9'd0, 9'd0, 8'h00);
      send_beat(OP_LOAD, 9'd511, 9'd511, 8'hFF);
      send_beat(OP_LOAD, 9'd511, 9'd0, 8'hA5);
      send_beat(OP_LOAD, 9'd0, 9'd511, 8'h5A);
      send_beat(OP_LOAD, 9'd5, 9'd0, 8'h11);
      render_pixel(9'd0, 9'd0);
      render_pixel(9'd511, 9'd511);
      render_pixel(9'd511, 9'd0);
      render_pixel(9'd0, 9'd511);
   endtask

   task automatic test_dimensions();
      // small image: load beyond it is dropped, render beyond it comes back outside
      configure(4, 4, UNITY, 0, 0, 0, UNITY, 0);
      send_beat(OP_LOAD, 9'd5, 9'd0, 8'h22);
      render_pixel(9'd5, 9'd0);
      // oversized dimensions clamp to the frame store size
      configure(1023, 1023, UNITY, 0, 0, 0, UNITY, 0);
      render_pixel(9'd511, 9'd511);
      configure(0, 0, UNITY, 0, 0, 0, UNITY, 0);
      render_pixel(9'd0, 9'd0);
      send_beat(OP_LOAD, 9'd0, 9'd0, 8'h77);
      configure(512, 512, UNITY, 0, 0, 0, UNITY, 0);
      render_pixel(9'd5, 9'd0);
   endtask

   task automatic test_rounding();
      configure(512, 512, UNITY / 2, 0, 0, 0, UNITY / 2, 0);
      render_pixel(9'd1, 9'd1);
      render_pixel(9'd3, 9'd3);
      // minus one half rounds away to minus one
      configure(512, 512, 0, 0, -(UNITY / 2), 0, UNITY, 0);
      render_pixel(9'd2, 9'd2);
      configure(512, 512, 0, 0, -(UNITY / 2) + 1, 0, UNITY, 0);
      render_pixel(9'd2, 9'd2);
      configure(512, 512, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      render_pixel(9'd511, 9'd511);
      render_pixel(9'd0, 9'd0);
      render_pixel(9'd511, 9'd0);
   endtask

   task automatic test_backpressure();
      int i;
      configure(4, 4, UNITY, 0, 0, 0, UNITY, 0);
      for (i = 0; i < 16; i++)
         send_beat(OP_LOAD, POS_W'(i % 4), POS_W'(i / 4), PIX_W'($urandom));
      send_idle = 0;
      hold_token <= ~hold_token;
      for (i = 0; i < 60; i++)
         render_pixel(POS_W'($urandom_range(0, 5)), POS_W'($urandom_range(0, 5)));
      drain_results();
      send_idle = 1;
   endtask

   task automatic test_random();
      int kind, fill, n, i, rw, rh, goal;
      int unsigned w, h;
      logic signed [COEF_W-1:0] c_xx, c_xy, c_xt, c_yx, c_yy, c_yt;
      logic [POS_W-1:0] x, y;
      goal = beats_sent + RANDOM_BEATS;
      while (beats_sent < goal) begin
         kind = $urandom_range(0, 9);
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle <= ($urandom_range(0, 3) != 0);
         w = $urandom_range(1, 24);
         h = $urandom_range(1, 24);
         if ($urandom_range(0, 7) == 0) w = ($urandom_range(0, 1) != 0) ? 512 : 1;
         if ($urandom_range(0, 7) == 0) h = ($urandom_range(0, 1) != 0) ? 512 : 1;
         c_xx = UNITY + spread(24576);
         c_xy = spread(24576);
         c_xt = spread(6 * UNITY);
         c_yx = spread(24576);
         c_yy = UNITY + spread(24576);
         c_yt = spread(6 * UNITY);
         case (kind)
            6, 7: begin
               // coefficients on the half grid hit exact ties
               c_xx = spread(4) * (UNITY / 2);
               c_xy = spread(4) * (UNITY / 2);
               c_xt = spread(16) * (UNITY / 2);
               c_yx = spread(4) * (UNITY / 2);
               c_yy = spread(4) * (UNITY / 2);
               c_yt = spread(16) * (UNITY / 2);
            end
            8: begin
               w = $urandom_range(0, 1023);
               h = $urandom_range(0, 1023);
               c_xx = $urandom;
               c_xy = $urandom;
               c_xt = $urandom;
               c_yx = $urandom;
               c_yy = $urandom;
               c_yt = $urandom;
            end
            9: begin
               case ($urandom_range(0, 3))
                  0: w = 0;
                  1: w = 1;
                  2: w = 512;
                  default: w = $urandom_range(513, 1023);
               endcase
               case ($urandom_range(0, 3))
                  0: h = 0;
                  1: h = 1;
                  2: h = 512;
                  default: h = $urandom_range(513, 1023);
               endcase
            end
            default: ;
         endcase
         configure(w, h, c_xx, c_xy, c_xt, c_yx, c_yy, c_yt);
         rw = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
         rh = (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
         fill = $urandom_range(0, 12);
         n = $urandom_range(20, 60);
         for (i = 0; i < fill + n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               x = POS_W'($urandom_range(0, 511));
               y = POS_W'($urandom_range(0, 511));
            end else begin
               x = POS_W'($urandom_range(0, (rw + 3 > 511) ? 511 : rw + 3));
               y = POS_W'($urandom_range(0, (rh + 3 > 511) ? 511 : rh + 3));
            end
            if (i < fill || $urandom_range(0, 9) < 3) send_beat(OP_LOAD, x, y, PIX_W'($urandom));
            else render_pixel(x, y);
         end
      end
   endtask

   // result side: per-beat random stall, long hold on request
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         stall_left = LONG_HOLD;
      end else if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         stall_left = recv_idle ? $urandom_range(0, 13) : 0;
      end
      rsp_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
   end

   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_PRINTS)
               $display("%0t: unexpected result beat pixel_out %h inside_res %b",
                        $time, rsp_pixel_out, rsp_inside_res);
         end else begin
            head = expected_pixels.pop_front();
            if (rsp_pixel_out !== head.pixel) begin
               mismatches++;
               if (mismatches <= MAX_PRINTS)
                  $display("%0t: pixel_out expected %h actual %h",
                           $time, head.pixel, rsp_pixel_out);
            end
            if (rsp_inside_res !== head.hit) begin
               mismatches++;
               if (mismatches <= MAX_PRINTS)
                  $display("%0t: inside_res expected %b actual %b",
                           $time, head.hit, rsp_inside_res);
            end
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("tb_inverse_affine_warp_nearest NOT OK");
      $finish;
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= OP_LOAD;
      req_pos_x     <= '0;
      req_pos_y     <= '0;
      req_pixel_in  <= '0;
      rsp_stall     <= 1'b0;
      csr_wr_en     <= 1'b0;
      csr_index     <= REG_IMAGE_WIDTH;
      csr_wdata     <= '0;
      frame_w = 10'd512;
      frame_h = 10'd512;
      m_xx = UNITY;
      m_xy = 0;
      m_xt = 0;
      m_yx = 0;
      m_yy = UNITY;
      m_yt = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_dimensions();
      test_rounding();
      test_backpressure();
      test_random();
      drain_results();
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("tb_inverse_affine_warp_nearest OK");
      else
         $display("tb_inverse_affine_warp_nearest NOT OK");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/iaw_pkg.sv
hw/rtl/iaw_ram.sv
hw/rtl/iaw_front.sv
hw/rtl/iaw_queue.sv
hw/rtl/iaw_back.sv
hw/rtl/inverse_affine_warp_nearest.sv
tb/tb_inverse_affine_warp_nearest.sv
